FILE: hdl/led_pixel_color_writer_assert.svh
// ---------------------------------------------------------------------------
// LED pixel colour writer: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LED_PIXEL_COLOR_WRITER_ASSERT_SVH
`define LED_PIXEL_COLOR_WRITER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPCW_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpcw: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LPCW_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpcw: next-cycle check failed");

`endif

FILE: hdl/lpcw_pkg.sv
// ---------------------------------------------------------------------------
// LED pixel colour writer package
// Sizes, codes, register reset values, queue entry and hue helpers.
// ---------------------------------------------------------------------------
package lpcw_pkg;

  localparam int NUM_LEDS = 64;
  localparam int LED_AW   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

  // Queue depth must be a power of two.
  localparam int QDEPTH = 2;
  localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam int CFG_AW = 4;
  localparam int DIV_W  = 32;
  localparam int DIV_CW = $clog2(DIV_W);

  localparam logic [14:0] ADC_FS_RESET = 15'd8192;
  localparam logic [30:0] DAC_FS_RESET = 31'd32768;
  localparam logic [7:0]  BMAX_RESET   = 8'd255;
  localparam logic [7:0]  HUE_SECTOR   = 8'd43;

  typedef enum logic [2:0] {
    KIND_RGB   = 3'd0,
    KIND_HSV   = 3'd1,
    KIND_ADC   = 3'd2,
    KIND_DAC   = 3'd3,
    KIND_CLEAR = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    REG_ADC_FS = 2'd0,
    REG_DAC_FS = 2'd1,
    REG_BMAX   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_RGB,
    OP_HSV,
    OP_LEVEL,
    OP_CLEAR
  } op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_HSV,
    BK_DIV_SCALE,
    BK_DIV_LEVEL,
    BK_EMIT
  } bk_state_t;

  typedef struct packed {
    logic [14:0] adc_fs;
    logic [30:0] dac_fs;
    logic [7:0]  bmax;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] index;
    logic [7:0]  c0;
    logic [7:0]  c1;
    logic [7:0]  c2;
    logic [2:0]  region;
    logic [7:0]  rem;
    logic [31:0] mag;
    logic        positive;
    logic        use_dac;
  } q_entry_t;

  function automatic logic [2:0] hue_region(input logic [7:0] h);
    logic [2:0] r;
    if (h < 8'd43) r = 3'd0;
    else if (h < 8'd86) r = 3'd1;
    else if (h < 8'd129) r = 3'd2;
    else if (h < 8'd172) r = 3'd3;
    else if (h < 8'd215) r = 3'd4;
    else r = 3'd5;
    return r;
  endfunction

  // Offset within the sector, scaled by six.
  function automatic logic [7:0] hue_rem(input logic [7:0] h, input logic [2:0] region);
    logic [7:0] base;
    logic [7:0] off;
    base = HUE_SECTOR * {5'b0, region};
    off  = h - base;
    return (off << 2) + (off << 1);
  endfunction

endpackage

FILE: hdl/lpcw_if.sv
// ---------------------------------------------------------------------------
// LED pixel colour writer channel interfaces
// Command and result channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface lpcw_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [15:0] led_index;
  logic [7:0]         chan_a;
  logic [7:0]         chan_b;
  logic [7:0]         chan_c;
  logic signed [31:0] level;

  modport source (output valid, kind, led_index, chan_a, chan_b, chan_c, level,
                  input ready);
  modport sink (input valid, kind, led_index, chan_a, chan_b, chan_c, level,
                output ready);
endinterface

interface lpcw_res_if;
  logic               valid;
  logic               ready;
  logic               written;
  logic signed [15:0] out_index;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;

  modport source (output valid, written, out_index, red, green, blue, input ready);
  modport sink (input valid, written, out_index, red, green, blue, output ready);
endinterface

FILE: hdl/lpcw_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one registered read port; a read of the address being
// written returns the new data.
// ---------------------------------------------------------------------------
module lpcw_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wa,
  input  logic [WIDTH-1:0]                           wd,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ra,
  output logic [WIDTH-1:0]                           rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (we && (wa == ra)) begin
      rd <= wd;
    end else begin
      rd <= mem[ra];
    end
  end

endmodule

FILE: hdl/lpcw_front.sv
// ---------------------------------------------------------------------------
// LED pixel colour writer front end
// Accepts commands, checks the index and classifies each item for the back
// end, folding grey HSV into a direct write.
// ---------------------------------------------------------------------------
module lpcw_front (
  lpcw_cmd_if.sink            cmd,
  input  logic                full,
  output logic                push,
  output lpcw_pkg::q_entry_t  push_data
);
  import lpcw_pkg::*;

  logic        in_range;
  logic [31:0] lvl_u;
  logic [2:0]  region;

  assign cmd.ready = !full;
  assign push      = cmd.valid && !full;

  assign in_range = !cmd.led_index[15] && (cmd.led_index[14:0] < 15'(NUM_LEDS));
  assign lvl_u    = cmd.level;
  assign region   = hue_region(cmd.chan_a);

  always_comb begin
    push_data          = '0;
    push_data.op       = OP_NONE;
    push_data.index    = cmd.led_index;
    push_data.c0       = cmd.chan_a;
    push_data.c1       = cmd.chan_b;
    push_data.c2       = cmd.chan_c;
    push_data.region   = region;
    push_data.rem      = hue_rem(cmd.chan_a, region);
    push_data.mag      = lvl_u[31] ? (~lvl_u + 32'd1) : lvl_u;
    push_data.positive = !lvl_u[31] && (lvl_u != 32'd0);
    push_data.use_dac  = 1'b0;
    case (kind_t'(cmd.kind))
      KIND_RGB: begin
        push_data.op = in_range ? OP_RGB : OP_NONE;
      end
      KIND_HSV: begin
        if (!in_range) begin
          push_data.op = OP_NONE;
        end else if (cmd.chan_b == 8'd0) begin
          push_data.op = OP_RGB;
          push_data.c0 = cmd.chan_c;
          push_data.c1 = cmd.chan_c;
        end else begin
          push_data.op = OP_HSV;
        end
      end
      KIND_ADC: begin
        push_data.op = in_range ? OP_LEVEL : OP_NONE;
      end
      KIND_DAC: begin
        push_data.op      = in_range ? OP_LEVEL : OP_NONE;
        push_data.use_dac = 1'b1;
      end
      KIND_CLEAR: begin
        push_data.op = OP_CLEAR;
      end
      default: begin
        push_data.op = OP_NONE;
      end
    endcase
  end

endmodule

FILE: hdl/lpcw_queue.sv
// ---------------------------------------------------------------------------
// LED pixel colour writer command queue
// Short FIFO of classified items between the front and back ends.
// ---------------------------------------------------------------------------
`include "led_pixel_color_writer_assert.svh"

module lpcw_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lpcw_pkg::q_entry_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output lpcw_pkg::q_entry_t head
);
  import lpcw_pkg::*;

  q_entry_t         entries [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QCW-1:0]   count;

  assign full  = (count == QCW'(QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  `LPCW_ASSERT_IMP(a_queue_bound, pop || push, (count <= QCW'(QDEPTH)) && !(pop && empty))

endmodule

FILE: hdl/lpcw_back.sv
// ---------------------------------------------------------------------------
// LED pixel colour writer back end
// Executes queued items: HSV conversion, level scaling through a shared
// restoring divider, framebuffer writes and the result register.
// ---------------------------------------------------------------------------
`include "led_pixel_color_writer_assert.svh"

module lpcw_back (
  input  logic               clk,
  input  logic               rst,
  input  lpcw_pkg::cfg_t     cfg,
  input  lpcw_pkg::q_entry_t head,
  input  logic               empty,
  output logic               pop,
  lpcw_res_if.source         res
);
  import lpcw_pkg::*;

  bk_state_t state, state_next;

  logic slot_free;
  logic emit;
  logic emit_written;
  logic emit_clear;
  logic [15:0] emit_index;
  logic [23:0] emit_color;

  logic res_valid;
  logic res_written;
  logic [15:0] res_index;
  logic [23:0] res_color;

  logic [NUM_LEDS-1:0] store_valid;
  logic                ram_we;
  logic [LED_AW-1:0]   ram_wa;
  logic [23:0]         ram_wd;
  logic [23:0]         ram_rd_data;

  logic [DIV_W-1:0]  dv_rem;
  logic [DIV_W-1:0]  dv_quo;
  logic [DIV_W-1:0]  dv_den;
  logic [DIV_CW-1:0] dv_cnt;
  logic [DIV_W:0]    dv_trial;
  logic [DIV_W:0]    dv_diff;
  logic              dv_ge;
  logic [DIV_W-1:0]  dv_rem_step;
  logic [DIV_W-1:0]  dv_quo_step;
  logic              dv_last;
  logic [DIV_W-1:0]  scale_q;

  logic [7:0]  bmax_eff;
  logic [30:0] fs_sel;
  logic [32:0] lv_diff;
  logic [31:0] lv_dividend;
  logic        lv_over;
  logic        lv_positive;
  logic [7:0]  lv_q8;
  logic [7:0]  lv_base;
  logic [7:0]  lv_blue;
  logic [23:0] lvl_color;

  logic [15:0] m1;
  logic [15:0] m2;
  logic [2:0]  hs_region;
  logic [7:0]  hs_s;
  logic [7:0]  hs_v;
  logic [7:0]  hs_k1;
  logic [7:0]  hs_k2;
  logic [15:0] mp;
  logic [15:0] mq;
  logic [15:0] mt;
  logic [23:0] hsv_color;

  logic [15:0] pend_index;
  logic [23:0] pend_color;

  assign slot_free = !res_valid || res.ready;

  // Restoring divider step, one quotient bit per cycle.
  assign dv_trial    = {dv_rem, dv_quo[DIV_W-1]};
  assign dv_diff     = dv_trial - {1'b0, dv_den};
  assign dv_ge       = !dv_diff[DIV_W];
  assign dv_rem_step = dv_ge ? dv_diff[DIV_W-1:0] : dv_trial[DIV_W-1:0];
  assign dv_quo_step = {dv_quo[DIV_W-2:0], dv_ge};
  assign dv_last     = (dv_cnt == DIV_CW'(DIV_W - 1));
  assign scale_q     = (dv_quo_step == '0) ? DIV_W'(1) : dv_quo_step;

  assign bmax_eff = (cfg.bmax == 8'd0) ? 8'd1 : cfg.bmax;
  assign fs_sel   = head.use_dac ? cfg.dac_fs : {16'b0, cfg.adc_fs};
  assign lv_diff  = {1'b0, head.mag} - {2'b0, fs_sel};

  assign lv_q8     = dv_quo_step[7:0];
  assign lv_base   = lv_over ? bmax_eff : lv_q8;
  assign lv_blue   = lv_over ? lv_q8 : 8'd0;
  assign lvl_color = lv_positive ? {8'd0, lv_base, lv_blue} : {lv_base, 8'd0, lv_blue};

  assign m1 = head.c1 * head.rem;
  assign m2 = head.c1 * (8'd255 - head.rem);
  assign mp = hs_v * (8'd255 - hs_s);
  assign mq = hs_v * (8'd255 - hs_k1);
  assign mt = hs_v * (8'd255 - hs_k2);

  always_comb begin
    case (hs_region)
      3'd0: hsv_color = {hs_v, mt[15:8], mp[15:8]};
      3'd1: hsv_color = {mq[15:8], hs_v, mp[15:8]};
      3'd2: hsv_color = {mp[15:8], hs_v, mt[15:8]};
      3'd3: hsv_color = {mp[15:8], mq[15:8], hs_v};
      3'd4: hsv_color = {mt[15:8], mp[15:8], hs_v};
      default: hsv_color = {hs_v, mp[15:8], mq[15:8]};
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!empty && (head.op == OP_HSV)) begin
          state_next = BK_HSV;
        end else if (!empty && (head.op == OP_LEVEL)) begin
          state_next = BK_DIV_SCALE;
        end
      end
      BK_HSV: begin
        state_next = BK_EMIT;
      end
      BK_DIV_SCALE: begin
        if (dv_last) begin
          state_next = BK_DIV_LEVEL;
        end
      end
      BK_DIV_LEVEL: begin
        if (dv_last) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (slot_free) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop          = 1'b0;
    emit         = 1'b0;
    emit_written = 1'b0;
    emit_clear   = 1'b0;
    emit_index   = head.index;
    emit_color   = '0;
    case (state)
      BK_IDLE: begin
        if (!empty) begin
          if ((head.op == OP_HSV) || (head.op == OP_LEVEL)) begin
            pop = 1'b1;
          end else if (slot_free) begin
            pop          = 1'b1;
            emit         = 1'b1;
            emit_written = (head.op != OP_NONE);
            emit_clear   = (head.op == OP_CLEAR);
            emit_color   = (head.op == OP_RGB) ? {head.c0, head.c1, head.c2} : 24'd0;
          end
        end
      end
      BK_EMIT: begin
        if (slot_free) begin
          emit         = 1'b1;
          emit_written = 1'b1;
          emit_index   = pend_index;
          emit_color   = pend_color;
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  assign ram_we = emit && emit_written && !emit_clear;
  assign ram_wa = emit_index[LED_AW-1:0];
  assign ram_wd = emit_color;

  lpcw_ram #(
    .WIDTH (24),
    .DEPTH (NUM_LEDS)
  ) u_store (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .ra  (ram_wa),
    .rd  (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      res_valid   <= 1'b0;
      store_valid <= '0;
    end else begin
      state <= state_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      if (emit_clear) begin
        store_valid <= '0;
      end else if (ram_we) begin
        store_valid[ram_wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_written <= emit_written;
      res_index   <= emit_index;
      res_color   <= emit_color;
    end
    if (pop) begin
      pend_index  <= head.index;
      hs_region   <= head.region;
      hs_s        <= head.c1;
      hs_v        <= head.c2;
      hs_k1       <= m1[15:8];
      hs_k2       <= m2[15:8];
      lv_over     <= !lv_diff[32];
      lv_dividend <= lv_diff[32] ? head.mag : lv_diff[31:0];
      lv_positive <= head.positive;
      dv_rem      <= '0;
      dv_quo      <= {1'b0, fs_sel};
      dv_den      <= {24'b0, bmax_eff};
      dv_cnt      <= '0;
    end
    case (state)
      BK_HSV: begin
        pend_color <= hsv_color;
      end
      BK_DIV_SCALE: begin
        if (dv_last) begin
          dv_rem <= '0;
          dv_quo <= lv_dividend;
          dv_den <= scale_q;
          dv_cnt <= '0;
        end else begin
          dv_rem <= dv_rem_step;
          dv_quo <= dv_quo_step;
          dv_cnt <= dv_cnt + 1'b1;
        end
      end
      BK_DIV_LEVEL: begin
        dv_rem <= dv_rem_step;
        dv_quo <= dv_quo_step;
        dv_cnt <= dv_cnt + 1'b1;
        if (dv_last) begin
          pend_color <= lvl_color;
        end
      end
      default: begin
      end
    endcase
  end

  assign res.valid     = res_valid;
  assign res.written   = res_written;
  assign res.out_index = res_index;
  assign res.red       = res_color[23:16];
  assign res.green     = res_color[15:8];
  assign res.blue      = res_color[7:0];

  `LPCW_ASSERT_NXT(a_store_readback, ram_we, store_valid[$past(ram_wa)] && (ram_rd_data == $past(ram_wd)))
  `LPCW_ASSERT_NXT(a_clear_empties, emit_clear, store_valid == '0)
  `LPCW_ASSERT_IMP(a_reject_black, res_valid && !res_written, res_color == 24'd0)

endmodule

FILE: hdl/led_pixel_color_writer.sv
// ---------------------------------------------------------------------------
// LED pixel colour writer
// Writes RGB, HSV or converter-level colours into a 64-entry LED framebuffer
// and returns the colour written for every command.
// ---------------------------------------------------------------------------
// Channel | Role   | Payload
// cmd     | input  | kind, led_index, chan_a, chan_b, chan_c, level
// res     | output | written, out_index, red, green, blue
// apb     | config | adc_fs at 0x0, dac_fs at 0x4, brightness_max at 0x8
//
// RGB, grey, rejected and clear-all items retire one per cycle while the result slot is free.
// HSV items pass through two multiplier stages in the back end.
// Level items make two 32-step passes of the shared divider.
// Clear-all empties the framebuffer by clearing its valid bits.
// Reset is synchronous and clears control state and registers only.
// A stalled result holds in the output register while the queue fills.
// ---------------------------------------------------------------------------
module led_pixel_color_writer (
  input  logic                        clk,
  input  logic                        rst,
  lpcw_cmd_if.sink                    cmd,
  lpcw_res_if.source                  res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lpcw_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import lpcw_pkg::*;

  cfg_t     cfg;
  logic     cfg_wr;
  reg_idx_t cfg_idx;
  logic     push;
  logic     full;
  logic     pop;
  logic     empty;
  q_entry_t push_data;
  q_entry_t head;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adc_fs <= ADC_FS_RESET;
      cfg.dac_fs <= DAC_FS_RESET;
      cfg.bmax   <= BMAX_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ADC_FS: cfg.adc_fs <= pwdata[14:0];
        REG_DAC_FS: cfg.dac_fs <= pwdata[30:0];
        REG_BMAX:   cfg.bmax   <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ADC_FS: prdata = {17'b0, cfg.adc_fs};
      REG_DAC_FS: prdata = {1'b0, cfg.dac_fs};
      REG_BMAX:   prdata = {24'b0, cfg.bmax};
      default:    prdata = '0;
    endcase
  end

  lpcw_front u_front (
    .cmd       (cmd),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  lpcw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  lpcw_back u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .res   (res)
  );

endmodule
